/* rtl/dkt_pkg.sv */
// dkt_pkg: shared types and constants for the distinct k-mer table
// used by dkt_window, dkt_store and distinct_kmer_table; no dependencies
`timescale 1ns / 1ps

package dkt_pkg;

  // table geometry
  localparam int TABLE_DEPTH = 1024;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  // k-mer geometry
  localparam int MAX_K  = 7;
  localparam int K_W    = 3;
  localparam int KMER_W = 14;

  // controller states
  typedef enum logic [0:0] {
    ST_IDLE,
    ST_SCAN
  } state_t;

  // input word
  typedef struct packed {
    logic [1:0] base_code;
    logic       last_of_string;
  } in_word_t;

  // result word
  typedef struct packed {
    logic              window_full;
    logic [KMER_W-1:0] kmer_value;
    logic              was_new;
    logic              dropped_full;
    logic [IDX_W-1:0]  slot_index;
    logic [CNT_W-1:0]  entries_stored;
  } out_word_t;

  // window status handed to the controller
  typedef struct packed {
    logic              full;
    logic [KMER_W-1:0] kval;
  } win_info_t;

endpackage

/* rtl/distinct_kmer_table.sv */
// distinct_kmer_table: top level, lookup controller around window and table
// depends on dkt_pkg, dkt_window, dkt_store
`timescale 1ns / 1ps

// One base is taken per word when start is high and busy is low; each word
// yields exactly one result, shown for one cycle with out_valid, and the
// receiver cannot hold it off. A word that does not complete a k-mer gives
// its result on the next cycle and busy stays low, so such words may follow
// every cycle. A word that completes a k-mer scans the stored entries one per
// cycle through the table's single read port, from slot 0 up to slot
// fill_count-1; busy stays high until its hit or miss result is registered.
// A miss writes the k-mer into slot fill_count; with the table full it is
// flagged and dropped. The table needs no clearing after reset.
module distinct_kmer_table (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  dkt_pkg::in_word_t           in_word,
  output logic                        out_valid,
  output dkt_pkg::out_word_t          out_word,
  input  logic                        cfg_we,
  input  logic [dkt_pkg::K_W-1:0]     cfg_wdata
);

  dkt_pkg::state_t            state_r, state_nxt;
  logic [dkt_pkg::CNT_W-1:0]  fill_r, fill_nxt;
  logic [dkt_pkg::CNT_W-1:0]  issue_r, issue_nxt;
  logic                       pend_r, pend_nxt;
  logic [dkt_pkg::IDX_W-1:0]  cmp_idx_r, cmp_idx_nxt;
  logic [dkt_pkg::KMER_W-1:0] kval_r, kval_nxt;
  logic                       out_valid_r, out_valid_nxt;
  dkt_pkg::out_word_t         out_word_r, out_word_nxt;

  dkt_pkg::win_info_t         win_info;
  logic                       accept;
  logic                       mem_we;
  logic [dkt_pkg::KMER_W-1:0] rdata;
  logic                       issue_done;
  logic                       hit;
  logic                       miss;
  logic                       table_full;

  assign busy   = (state_r != dkt_pkg::ST_IDLE);
  assign accept = start && !busy;

  dkt_window u_window (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .accept    (accept),
    .in_word   (in_word),
    .win_info  (win_info)
  );

  dkt_store u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (fill_r[dkt_pkg::IDX_W-1:0]),
    .wdata (kval_r),
    .raddr (issue_r[dkt_pkg::IDX_W-1:0]),
    .rdata (rdata)
  );

  // scan status: compare returning entry, detect end of stored entries
  assign issue_done = (issue_r >= fill_r);
  assign hit        = (state_r == dkt_pkg::ST_SCAN) && pend_r && (rdata == kval_r);
  assign miss       = (state_r == dkt_pkg::ST_SCAN) && !hit && issue_done;
  assign table_full = (fill_r >= dkt_pkg::CNT_W'(dkt_pkg::TABLE_DEPTH));

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      dkt_pkg::ST_IDLE: begin
        if (accept && win_info.full) begin
          state_nxt = dkt_pkg::ST_SCAN;
        end
      end
      dkt_pkg::ST_SCAN: begin
        if (hit || miss) begin
          state_nxt = dkt_pkg::ST_IDLE;
        end
      end
      default: state_nxt = dkt_pkg::ST_IDLE;
    endcase
  end

  // datapath and result
  always_comb begin
    fill_nxt      = fill_r;
    issue_nxt     = issue_r;
    pend_nxt      = 1'b0;
    cmp_idx_nxt   = issue_r[dkt_pkg::IDX_W-1:0];
    kval_nxt      = kval_r;
    out_valid_nxt = 1'b0;
    out_word_nxt  = out_word_r;
    mem_we        = 1'b0;
    unique case (state_r)
      dkt_pkg::ST_IDLE: begin
        if (accept) begin
          kval_nxt  = win_info.kval;
          issue_nxt = '0;
          if (!win_info.full) begin
            out_valid_nxt               = 1'b1;
            out_word_nxt                = '0;
            out_word_nxt.entries_stored = fill_r;
          end
        end
      end
      dkt_pkg::ST_SCAN: begin
        // issue the next read while entries remain
        if (!issue_done) begin
          issue_nxt = issue_r + dkt_pkg::CNT_W'(1);
          pend_nxt  = 1'b1;
        end
        if (hit) begin
          out_valid_nxt               = 1'b1;
          out_word_nxt.window_full    = 1'b1;
          out_word_nxt.kmer_value     = kval_r;
          out_word_nxt.was_new        = 1'b0;
          out_word_nxt.dropped_full   = 1'b0;
          out_word_nxt.slot_index     = cmp_idx_r;
          out_word_nxt.entries_stored = fill_r;
        end else if (miss) begin
          out_valid_nxt             = 1'b1;
          out_word_nxt.window_full  = 1'b1;
          out_word_nxt.kmer_value   = kval_r;
          out_word_nxt.was_new      = 1'b1;
          if (table_full) begin
            out_word_nxt.dropped_full   = 1'b1;
            out_word_nxt.slot_index     = '0;
            out_word_nxt.entries_stored = fill_r;
          end else begin
            mem_we                      = 1'b1;
            fill_nxt                    = fill_r + dkt_pkg::CNT_W'(1);
            out_word_nxt.dropped_full   = 1'b0;
            out_word_nxt.slot_index     = fill_r[dkt_pkg::IDX_W-1:0];
            out_word_nxt.entries_stored = fill_r + dkt_pkg::CNT_W'(1);
          end
        end
      end
      default: begin
        out_valid_nxt = 1'b0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dkt_pkg::ST_IDLE;
      fill_r      <= '0;
      issue_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      issue_r     <= issue_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cmp_idx_r  <= cmp_idx_nxt;
    kval_r     <= kval_nxt;
    out_word_r <= out_word_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

/* rtl/dkt_window.sv */
// dkt_window: k-mer length register and the sliding base window
// depends on dkt_pkg
`timescale 1ns / 1ps

module dkt_window (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [dkt_pkg::K_W-1:0]     cfg_wdata,
  input  logic                        accept,
  input  dkt_pkg::in_word_t           in_word,
  output dkt_pkg::win_info_t          win_info
);

  logic [dkt_pkg::K_W-1:0]    kmer_len_r;
  logic [dkt_pkg::KMER_W-1:0] window_r;
  logic [dkt_pkg::K_W-1:0]    seen_r;

  logic [dkt_pkg::K_W-1:0]    k_eff;
  logic [dkt_pkg::KMER_W:0]   mask_wide;
  logic [dkt_pkg::KMER_W-1:0] window_nxt;
  logic [dkt_pkg::K_W-1:0]    seen_nxt;

  // clamp k into 1..MAX_K
  always_comb begin
    if (kmer_len_r == '0) begin
      k_eff = dkt_pkg::K_W'(1);
    end else if (kmer_len_r > dkt_pkg::K_W'(dkt_pkg::MAX_K)) begin
      k_eff = dkt_pkg::K_W'(dkt_pkg::MAX_K);
    end else begin
      k_eff = kmer_len_r;
    end
  end

  // shift in the new base, keep 2k bits, saturate the base count at k
  always_comb begin
    mask_wide  = ((dkt_pkg::KMER_W+1)'(1) << {k_eff, 1'b0}) - (dkt_pkg::KMER_W+1)'(1);
    window_nxt = {window_r[dkt_pkg::KMER_W-3:0], in_word.base_code}
                 & mask_wide[dkt_pkg::KMER_W-1:0];
    seen_nxt   = (seen_r < k_eff) ? seen_r + dkt_pkg::K_W'(1) : seen_r;
  end

  assign win_info.full = (seen_nxt >= k_eff);
  assign win_info.kval = window_nxt;

  // length register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kmer_len_r <= dkt_pkg::K_W'(3);
    end else if (cfg_we) begin
      kmer_len_r <= cfg_wdata;
    end
  end

  // window and base count, cleared after the last base of a string
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= '0;
      seen_r   <= '0;
    end else if (accept) begin
      if (in_word.last_of_string) begin
        window_r <= '0;
        seen_r   <= '0;
      end else begin
        window_r <= window_nxt;
        seen_r   <= seen_nxt;
      end
    end
  end

endmodule

/* rtl/dkt_store.sv */
// dkt_store: k-mer table memory, one write port and one registered read port
// depends on dkt_pkg
`timescale 1ns / 1ps

module dkt_store (
  input  logic                        clk,
  input  logic                        we,
  input  logic [dkt_pkg::IDX_W-1:0]   waddr,
  input  logic [dkt_pkg::KMER_W-1:0]  wdata,
  input  logic [dkt_pkg::IDX_W-1:0]   raddr,
  output logic [dkt_pkg::KMER_W-1:0]  rdata
);

  logic [dkt_pkg::KMER_W-1:0] mem [dkt_pkg::TABLE_DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, registered
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
